@@ sv/dqe_pkg.sv @@
// shared types and constants for the double-ended queue engine
package dqe_pkg;

	localparam int DEPTH = 64;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;
	localparam int GRP   = 8;
	localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
	localparam int GCW   = $clog2(GRP + 1);

	typedef enum logic [2:0] {
		OP_PUSH_BACK,
		OP_PUSH_FRONT,
		OP_POP,
		OP_REPLACE,
		OP_SORT,
		OP_REVERSE,
		OP_DEDUP,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL,
		ST_NOMATCH
	} status_t;

	typedef enum logic [2:0] {
		C_HOLD,
		C_SHR,
		C_SHL,
		C_WRITE,
		C_REPL,
		C_TAG,
		C_ROT,
		C_XP
	} cell_cmd_t;

	typedef enum logic [1:0] {
		K_SORT,
		K_REV,
		K_DEDUP
	} key_t;

	typedef struct packed {
		logic [DW-1:0] value;
		logic [IW-1:0] tag;
		logic          dup;
	} ent_t;

	typedef struct packed {
		cell_cmd_t     cmd;
		logic          phase;
		key_t          key;
		logic [CW-1:0] count;
		logic [DW-1:0] val;
		logic [DW-1:0] chg;
		ent_t          bcast;
	} ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ROT,
		S_XPOSE,
		S_TAIL,
		S_EMIT
	} state_t;

endpackage

@@ sv/dqe_cell.sv @@
// one queue cell: holds one entry and trades it with its neighbors
module dqe_cell (
	input  logic                   clk,
	input  logic [dqe_pkg::IW-1:0] idx,
	input  dqe_pkg::ctl_t          ctl,
	input  dqe_pkg::ent_t          left_i,
	input  dqe_pkg::ent_t          right_i,
	input  logic                   swap_l,
	output dqe_pkg::ent_t          ent_o,
	output logic                   swap_o,
	output logic                   last_o,
	output logic                   match_o
);

	dqe_pkg::ent_t ent_q;
	dqe_pkg::ent_t ent_d;
	logic          match_q;
	logic          match_d;
	logic [dqe_pkg::CW-1:0] pos;
	logic          active;
	logic          pair_ok;
	logic          eq_val;
	logic          mark;
	logic          gt;

	// position decode against the live length
	assign pos     = dqe_pkg::CW'(idx);
	assign active  = pos < ctl.count;
	assign pair_ok = (pos + dqe_pkg::CW'(1)) < ctl.count;
	assign last_o  = (pos + dqe_pkg::CW'(1)) == ctl.count;
	assign eq_val  = ent_q.value == ctl.val;

	// duplicate mark against the entry broadcast from the head cell
	assign mark = (ctl.cmd == dqe_pkg::C_ROT) && active &&
		(ent_q.value == ctl.bcast.value) && (ent_q.tag > ctl.bcast.tag);

	always_comb begin
		ent_o     = ent_q;
		ent_o.dup = ent_q.dup | mark;
	end

	// compare with the right neighbor for the transposition step
	always_comb begin
		case (ctl.key)
			dqe_pkg::K_SORT:  gt = $signed(ent_q.value) > $signed(right_i.value);
			dqe_pkg::K_REV:   gt = ent_q.tag < right_i.tag;
			dqe_pkg::K_DEDUP: gt = {ent_q.dup, ent_q.tag} > {right_i.dup, right_i.tag};
			default:          gt = 1'b0;
		endcase
	end

	assign swap_o = (ctl.cmd == dqe_pkg::C_XP) && (idx[0] == ctl.phase) && pair_ok && gt;

	// next entry
	always_comb begin
		ent_d   = ent_q;
		match_d = match_q;
		case (ctl.cmd)
			dqe_pkg::C_SHR: ent_d = left_i;
			dqe_pkg::C_SHL: ent_d = right_i;
			dqe_pkg::C_WRITE: begin
				if (pos == ctl.count) begin
					ent_d.value = ctl.val;
				end
			end
			dqe_pkg::C_REPL: begin
				match_d = active && eq_val;
				if (active && eq_val) begin
					ent_d.value = ctl.chg;
				end
			end
			dqe_pkg::C_TAG: begin
				ent_d.tag = idx;
				ent_d.dup = 1'b0;
			end
			dqe_pkg::C_ROT: begin
				if (active) begin
					ent_d = last_o ? ctl.bcast : right_i;
				end
			end
			dqe_pkg::C_XP: begin
				if (swap_o) begin
					ent_d = right_i;
				end else if (swap_l) begin
					ent_d = left_i;
				end
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q   <= ent_d;
		match_q <= match_d;
	end

	assign match_o = match_q;

endmodule

@@ sv/double_ended_queue_engine.sv @@
// top level of the double-ended queue engine
// Usage:
// One command transaction on the input channel (opcode, value, change) gives
// exactly one result transaction on the output channel. Entries sit in a row
// of cells in order, head in cell 0; pops and front pushes are single shifts.
// Push, pop, replace and no-op go through the execute, tail and emit states
// to the result register. Sort and reverse add an odd-even transposition
// over the n live entries; dedup adds a rotation (marking repeats against
// the head cell) and a transposition that compacts them. The length of
// whole-store commands is set by the neighbor-only exchange of the cell row.
// One command is in flight at a time: in_stall is high from acceptance until
// the result is written.
// The result waits in an output register; a stalled receiver holds it and the
// next command runs but waits before writing its own result.
// Reset empties the queue and clears the output valid; cell contents are not
// reset and are never shown outside the live range.
module double_ended_queue_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] value,
	input  logic signed [31:0] change,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] popped_value,
	output logic [1:0]         status,
	output logic [6:0]         match_count,
	output logic [6:0]         length,
	output logic signed [31:0] head_value,
	output logic signed [31:0] tail_value
);

	dqe_pkg::state_t               state_q, state_d;
	dqe_pkg::op_t                  op_q;
	logic [dqe_pkg::DW-1:0]        val_q, chg_q;
	logic [dqe_pkg::CW-1:0]        count_q, count_d;
	logic [dqe_pkg::CW-1:0]        step_q, step_d;
	logic [dqe_pkg::CW-1:0]        dupn_q, dupn_d;
	logic [dqe_pkg::DW-1:0]        popped_q, popped_d;
	dqe_pkg::status_t              stat_q, stat_d;
	logic [dqe_pkg::DW-1:0]        grp_tail_q [dqe_pkg::NGRP];
	logic [dqe_pkg::GCW-1:0]       grp_match_q [dqe_pkg::NGRP];
	logic [dqe_pkg::DW-1:0]        grp_tail_d [dqe_pkg::NGRP];
	logic [dqe_pkg::GCW-1:0]       grp_match_d [dqe_pkg::NGRP];
	logic                          out_valid_q;
	logic                          emit;
	logic [dqe_pkg::DW-1:0]        popped_out_q, head_q, tail_q;
	logic [1:0]                    status_q;
	logic [6:0]                    match_q, length_q;
	logic [dqe_pkg::DW-1:0]        tail_all;
	logic [dqe_pkg::CW-1:0]        match_sum;
	dqe_pkg::status_t              final_stat;
	dqe_pkg::ctl_t                 ctl;
	dqe_pkg::ent_t                 cell_ent [dqe_pkg::DEPTH];
	logic [dqe_pkg::DEPTH-1:0]     swap_v, last_v, match_v;

	assign in_stall = state_q != dqe_pkg::S_IDLE;

	// row of cells
	for (genvar i = 0; i < dqe_pkg::DEPTH; i++) begin : g_cell
		dqe_pkg::ent_t left_ent, right_ent;
		logic          swap_in;
		if (i == 0) begin : g_first
			always_comb begin
				left_ent.value = val_q;
				left_ent.tag   = '0;
				left_ent.dup   = 1'b0;
			end
			assign swap_in = 1'b0;
		end else begin : g_mid
			assign left_ent = cell_ent[i-1];
			assign swap_in  = swap_v[i-1];
		end
		if (i == dqe_pkg::DEPTH - 1) begin : g_last
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = cell_ent[i+1];
		end
		dqe_cell u_cell (
			.clk     (clk),
			.idx     (dqe_pkg::IW'(i)),
			.ctl     (ctl),
			.left_i  (left_ent),
			.right_i (right_ent),
			.swap_l  (swap_in),
			.ent_o   (cell_ent[i]),
			.swap_o  (swap_v[i]),
			.last_o  (last_v[i]),
			.match_o (match_v[i])
		);
	end

	// sequencer: next state and cell commands
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		step_d    = step_q;
		dupn_d    = dupn_q;
		popped_d  = popped_q;
		stat_d    = stat_q;
		emit      = 1'b0;
		ctl.cmd   = dqe_pkg::C_HOLD;
		ctl.phase = step_q[0];
		ctl.key   = dqe_pkg::K_SORT;
		ctl.count = count_q;
		ctl.val   = val_q;
		ctl.chg   = chg_q;
		ctl.bcast = cell_ent[0];
		case (op_q)
			dqe_pkg::OP_REVERSE: ctl.key = dqe_pkg::K_REV;
			dqe_pkg::OP_DEDUP:   ctl.key = dqe_pkg::K_DEDUP;
			default:             ctl.key = dqe_pkg::K_SORT;
		endcase
		case (state_q)
			dqe_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = dqe_pkg::S_EXEC;
				end
			end
			dqe_pkg::S_EXEC: begin
				popped_d = '0;
				stat_d   = dqe_pkg::ST_OK;
				step_d   = '0;
				dupn_d   = '0;
				state_d  = dqe_pkg::S_TAIL;
				case (op_q)
					dqe_pkg::OP_PUSH_BACK, dqe_pkg::OP_PUSH_FRONT: begin
						if (count_q == dqe_pkg::CW'(dqe_pkg::DEPTH)) begin
							stat_d = dqe_pkg::ST_FULL;
						end else begin
							ctl.cmd = (op_q == dqe_pkg::OP_PUSH_BACK) ?
								dqe_pkg::C_WRITE : dqe_pkg::C_SHR;
							count_d = count_q + dqe_pkg::CW'(1);
						end
					end
					dqe_pkg::OP_POP: begin
						if (count_q == '0) begin
							stat_d = dqe_pkg::ST_EMPTY;
						end else begin
							ctl.cmd  = dqe_pkg::C_SHL;
							popped_d = cell_ent[0].value;
							count_d  = count_q - dqe_pkg::CW'(1);
						end
					end
					dqe_pkg::OP_REPLACE: begin
						if (count_q == '0) begin
							stat_d = dqe_pkg::ST_EMPTY;
						end else begin
							ctl.cmd = dqe_pkg::C_REPL;
						end
					end
					dqe_pkg::OP_SORT, dqe_pkg::OP_REVERSE, dqe_pkg::OP_DEDUP: begin
						ctl.cmd = dqe_pkg::C_TAG;
						if (count_q != '0) begin
							state_d = (op_q == dqe_pkg::OP_DEDUP) ?
								dqe_pkg::S_ROT : dqe_pkg::S_XPOSE;
						end
					end
					default: state_d = dqe_pkg::S_TAIL;
				endcase
			end
			dqe_pkg::S_ROT: begin
				ctl.cmd = dqe_pkg::C_ROT;
				dupn_d  = dupn_q + dqe_pkg::CW'(cell_ent[0].dup);
				step_d  = step_q + dqe_pkg::CW'(1);
				if (step_q + dqe_pkg::CW'(1) == count_q) begin
					step_d  = '0;
					state_d = dqe_pkg::S_XPOSE;
				end
			end
			dqe_pkg::S_XPOSE: begin
				ctl.cmd = dqe_pkg::C_XP;
				step_d  = step_q + dqe_pkg::CW'(1);
				if (step_q + dqe_pkg::CW'(1) == count_q) begin
					state_d = dqe_pkg::S_TAIL;
					if (op_q == dqe_pkg::OP_DEDUP) begin
						count_d = count_q - dupn_q;
					end
				end
			end
			dqe_pkg::S_TAIL: begin
				state_d = dqe_pkg::S_EMIT;
			end
			dqe_pkg::S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit    = 1'b1;
					state_d = dqe_pkg::S_IDLE;
				end
			end
			default: state_d = dqe_pkg::S_IDLE;
		endcase
	end

	// first level of the tail select and match count, per group of cells
	always_comb begin
		for (int g = 0; g < dqe_pkg::NGRP; g++) begin
			grp_tail_d[g]  = '0;
			grp_match_d[g] = '0;
			for (int j = 0; j < dqe_pkg::GRP; j++) begin
				if (g * dqe_pkg::GRP + j < dqe_pkg::DEPTH) begin
					if (last_v[g * dqe_pkg::GRP + j]) begin
						grp_tail_d[g] = grp_tail_d[g] | cell_ent[g * dqe_pkg::GRP + j].value;
					end
					grp_match_d[g] = grp_match_d[g] +
						dqe_pkg::GCW'(match_v[g * dqe_pkg::GRP + j]);
				end
			end
		end
	end

	// second level, read while emitting; matches only count for a replace that ran
	always_comb begin
		tail_all  = '0;
		match_sum = '0;
		for (int g = 0; g < dqe_pkg::NGRP; g++) begin
			tail_all  = tail_all | grp_tail_q[g];
			match_sum = match_sum + dqe_pkg::CW'(grp_match_q[g]);
		end
		final_stat = stat_q;
		if (op_q != dqe_pkg::OP_REPLACE || stat_q != dqe_pkg::ST_OK) begin
			match_sum = '0;
		end else if (match_sum == '0) begin
			final_stat = dqe_pkg::ST_NOMATCH;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dqe_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (state_q == dqe_pkg::S_IDLE && in_valid) begin
			op_q  <= dqe_pkg::op_t'(opcode);
			val_q <= value;
			chg_q <= change;
		end
		step_q   <= step_d;
		dupn_q   <= dupn_d;
		popped_q <= popped_d;
		stat_q   <= stat_d;
		if (state_q == dqe_pkg::S_TAIL) begin
			grp_tail_q  <= grp_tail_d;
			grp_match_q <= grp_match_d;
		end
		if (emit) begin
			popped_out_q <= popped_q;
			status_q     <= final_stat;
			match_q      <= match_sum[6:0];
			length_q     <= count_q[6:0];
			head_q       <= (count_q != '0) ? cell_ent[0].value : '0;
			tail_q       <= tail_all;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_out_q;
	assign status       = status_q;
	assign match_count  = match_q;
	assign length       = length_q;
	assign head_value   = head_q;
	assign tail_value   = tail_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dqe_pkg::CW'(dqe_pkg::DEPTH))
		else $error("entry count beyond depth");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		emit && final_stat == dqe_pkg::ST_FULL |=> length == 7'(dqe_pkg::DEPTH))
		else $error("full status with queue not full");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		emit && final_stat == dqe_pkg::ST_EMPTY |=> length == '0 && head_value == '0)
		else $error("empty status with entries present");

	a_match_ok: assert property (@(posedge clk) disable iff (!arst_n)
		emit && match_sum != '0 |-> final_stat == dqe_pkg::ST_OK)
		else $error("matches reported with error status");

endmodule
